[hw/rtl/fts_pkg.sv]
// Shared constants, types and control encodings for the frame time statistics block.
package fts_pkg;

  localparam int TICK_BITS    = 32;
  localparam int TOTAL_BITS   = 48;
  localparam int FRAME_BITS   = 32;
  localparam int WSUM_BITS    = TICK_BITS + 1;
  localparam int QUOT_BITS    = 32;
  localparam int CNT_BITS     = $clog2(QUOT_BITS);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DELTA     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DELTA     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd2;

  localparam logic [TICK_BITS-1:0] MAX_DELTA_RST     = 32'd20000000;
  localparam logic [TICK_BITS-1:0] MIN_DELTA_RST     = 32'd0;
  localparam logic [TICK_BITS-1:0] WINDOW_LENGTH_RST = 32'd1000000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP,
    S_ACCUM,
    S_CHECK,
    S_WIN_DIV,
    S_WIN_WAIT,
    S_MARK,
    S_ALL_WAIT,
    S_EMIT
  } fts_state_t;

  typedef struct packed {
    logic capture;
    logic clamp;
    logic accum;
    logic check;
    logic div_start;
    logic div_sel_all;
    logic take_mean;
    logic mark;
    logic take_overall;
    logic load_out;
  } fts_cmd_t;

  typedef struct packed {
    logic closed;
    logic div_done;
  } fts_status_t;

endpackage

[hw/rtl/fts_div.sv]
// Shared restoring divider, one quotient bit per cycle, saturating at QUOT_BITS.
module fts_div import fts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TOTAL_BITS-1:0] num,
  input  logic [TICK_BITS-1:0]  den,
  output logic                  busy,
  output logic                  done,
  output logic [QUOT_BITS-1:0]  quot
);

  logic [TICK_BITS-1:0] rem;
  logic [TICK_BITS-1:0] den_r;
  logic [QUOT_BITS-1:0] quo;
  logic [CNT_BITS-1:0]  count;
  logic [TICK_BITS:0]   shifted;
  logic                 fits;
  logic                 last;
  logic                 saturate;

  assign shifted  = {rem, quo[QUOT_BITS-1]};
  assign fits     = shifted >= {1'b0, den_r};
  assign last     = count == CNT_BITS'(QUOT_BITS - 1);
  assign saturate = TOTAL_BITS'(num[TOTAL_BITS-1:QUOT_BITS]) >= TOTAL_BITS'(den);
  assign quot     = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= '0;
        if (saturate) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        count <= count + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= TICK_BITS'(num[TOTAL_BITS-1:QUOT_BITS]);
      quo   <= saturate ? '1 : num[QUOT_BITS-1:0];
    end else if (busy) begin
      rem <= fits ? TICK_BITS'(shifted - {1'b0, den_r}) : shifted[TICK_BITS-1:0];
      quo <= {quo[QUOT_BITS-2:0], fits};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (busy && last && !start) |=> (done && !busy))
    else $error("divider did not finish after its last step");

endmodule

[hw/rtl/fts_dpath.sv]
// Datapath: configuration, accumulators, statistics, divider and output register.
module fts_dpath import fts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  fts_cmd_t                cmd,
  output fts_status_t             status,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TICK_BITS-1:0]    cfg_data,
  input  logic [TICK_BITS-1:0]    now_ticks,
  output logic [TICK_BITS-1:0]    delta_ticks,
  output logic [TOTAL_BITS-1:0]   total_ticks,
  output logic [FRAME_BITS-1:0]   frames_seen,
  output logic                    window_closed,
  output logic [QUOT_BITS-1:0]    mean_frame,
  output logic [QUOT_BITS-1:0]    lowest_frame,
  output logic [QUOT_BITS-1:0]    highest_frame,
  output logic [QUOT_BITS-1:0]    overall_mean
);

  logic [TICK_BITS-1:0]  max_delta;
  logic [TICK_BITS-1:0]  min_delta;
  logic [TICK_BITS-1:0]  window_length;
  logic [TICK_BITS-1:0]  stamp;
  logic [TICK_BITS-1:0]  previous_stamp;
  logic [TICK_BITS-1:0]  delta;
  logic [TOTAL_BITS-1:0] total_sum;
  logic [FRAME_BITS-1:0] frame_counter;
  logic [WSUM_BITS-1:0]  window_sum;
  logic [FRAME_BITS-1:0] window_frames;
  logic [QUOT_BITS-1:0]  last_mean;
  logic [QUOT_BITS-1:0]  low_mark;
  logic [QUOT_BITS-1:0]  high_mark;
  logic [QUOT_BITS-1:0]  running_mean;
  logic                  closed;
  logic [TICK_BITS-1:0]  diff;
  logic [TICK_BITS-1:0]  upper;
  logic [TOTAL_BITS-1:0] div_num;
  logic [TICK_BITS-1:0]  div_den;
  logic                  div_busy;
  logic                  div_done;
  logic [QUOT_BITS-1:0]  div_quot;

  assign diff  = stamp - previous_stamp;
  assign upper = (diff > max_delta) ? max_delta : diff;

  assign div_num = cmd.div_sel_all ? total_sum : TOTAL_BITS'(window_sum);
  assign div_den = cmd.div_sel_all ? frame_counter : window_frames;

  assign status.closed   = closed;
  assign status.div_done = div_done;

  fts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delta     <= MAX_DELTA_RST;
      min_delta     <= MIN_DELTA_RST;
      window_length <= WINDOW_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAX_DELTA:     max_delta     <= cfg_data;
        CFG_MIN_DELTA:     min_delta     <= cfg_data;
        CFG_WINDOW_LENGTH: window_length <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_stamp <= '0;
      total_sum      <= '0;
      frame_counter  <= '0;
      window_sum     <= '0;
      window_frames  <= '0;
      last_mean      <= '0;
      low_mark       <= '1;
      high_mark      <= '0;
      running_mean   <= '0;
      closed         <= 1'b0;
    end else begin
      if (cmd.clamp) begin
        previous_stamp <= stamp;
      end
      if (cmd.accum) begin
        total_sum     <= total_sum + TOTAL_BITS'(delta);
        frame_counter <= frame_counter + 1'b1;
        window_sum    <= window_sum + WSUM_BITS'(delta);
        window_frames <= window_frames + 1'b1;
      end
      if (cmd.check) begin
        closed <= window_sum >= WSUM_BITS'(window_length);
      end
      if (cmd.take_mean) begin
        last_mean <= div_quot;
      end
      if (cmd.mark) begin
        if (last_mean > high_mark) begin
          high_mark <= last_mean;
        end
        if (last_mean < low_mark) begin
          low_mark <= last_mean;
        end
        window_sum    <= '0;
        window_frames <= '0;
      end
      if (cmd.take_overall) begin
        running_mean <= div_quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stamp <= now_ticks;
    end
    if (cmd.clamp) begin
      delta <= (upper < min_delta) ? min_delta : upper;
    end
    if (cmd.load_out) begin
      delta_ticks   <= delta;
      total_ticks   <= total_sum;
      frames_seen   <= frame_counter;
      window_closed <= closed;
      mean_frame    <= last_mean;
      lowest_frame  <= low_mark;
      highest_frame <= high_mark;
      overall_mean  <= running_mean;
    end
  end

  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.accum || cmd.load_out) |-> !div_busy)
    else $error("accumulators touched while a division runs");

endmodule

[hw/rtl/fts_ctrl.sv]
// Controller: sequences one frame transaction through the datapath and owns in/out handshakes.
module fts_ctrl import fts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output fts_cmd_t    cmd,
  input  fts_status_t status
);

  fts_state_t state;
  fts_state_t state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_WIN_DIV;
      end
      S_WIN_DIV: begin
        if (status.closed) begin
          cmd.div_start = 1'b1;
          state_next    = S_WIN_WAIT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_WIN_WAIT: begin
        if (status.div_done) begin
          cmd.take_mean = 1'b1;
          state_next    = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark        = 1'b1;
        cmd.div_start   = 1'b1;
        cmd.div_sel_all = 1'b1;
        state_next      = S_ALL_WAIT;
      end
      S_ALL_WAIT: begin
        if (status.div_done) begin
          cmd.take_overall = 1'b1;
          state_next       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten while its transaction waits");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while one is in progress");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_WIN_WAIT || state == S_ALL_WAIT))
    else $error("division finished outside a wait state");

endmodule

[hw/rtl/frame_time_statistics.sv]
// Top level of the frame time statistics block: controller plus datapath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  now_ticks
//   output   out        out_valid/out_stall  delta_ticks .. overall_mean
//   config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A frame closing no window is clamped, accumulated and checked, then registered out.
// A frame closing a window adds two divisions, one for each mean;
// the divider retires one quotient bit per cycle and is shared by both means.
// Reset is synchronous and leaves the block idle and ready for a transaction.
// A finished result waits in the output register while the next transaction is accepted;
// only a second result meeting a still-stalled output holds the controller.
module frame_time_statistics import fts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [TICK_BITS-1:0]    now_ticks,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [TICK_BITS-1:0]    delta_ticks,
  output logic [TOTAL_BITS-1:0]   total_ticks,
  output logic [FRAME_BITS-1:0]   frames_seen,
  output logic                    window_closed,
  output logic [QUOT_BITS-1:0]    mean_frame,
  output logic [QUOT_BITS-1:0]    lowest_frame,
  output logic [QUOT_BITS-1:0]    highest_frame,
  output logic [QUOT_BITS-1:0]    overall_mean,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TICK_BITS-1:0]    cfg_data
);

  fts_cmd_t    cmd;
  fts_status_t status;

  assign cfg_ready = 1'b1;

  fts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  fts_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .now_ticks     (now_ticks),
    .delta_ticks   (delta_ticks),
    .total_ticks   (total_ticks),
    .frames_seen   (frames_seen),
    .window_closed (window_closed),
    .mean_frame    (mean_frame),
    .lowest_frame  (lowest_frame),
    .highest_frame (highest_frame),
    .overall_mean  (overall_mean)
  );

endmodule
